/* hw/rtl/round_robin_quantum_scheduler_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin quantum scheduler checks.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_DEFINES_SVH

// Clocked check that is switched off while reset is high.
`define RRQS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rrqs check failed");

// Clocked check that also holds across reset.
`define RRQS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rrqs reset check failed");

`endif

/* hw/rtl/rrqs_pkg.sv */
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared constants, state codes and table write command for the scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

  // Number of task slots and the width of a slot index.
  localparam int TASK_COUNT = 8;
  localparam int TASK_W     = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  // Fixed field widths.
  localparam int SLOT_W  = 3;
  localparam int BURST_W = 16;
  localparam int Q_W     = 8;
  localparam int CLOCK_W = 24;

  localparam logic [CLOCK_W-1:0] CLOCK_MAX = '1;

  // Request modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SLICE,
    ST_EMIT
  } state_t;

  // Write command from the sequencer to the task table.
  typedef struct packed {
    logic               load_en;
    logic [TASK_W-1:0]  load_idx;
    logic [BURST_W-1:0] load_burst;
    logic               upd_en;
    logic [TASK_W-1:0]  upd_idx;
    logic [BURST_W-1:0] upd_rem;
  } table_wr_t;

endpackage

/* hw/rtl/rrqs_task_table.sv */
// ----------------------------------------------------------------------------
// rrqs_task_table
// Burst and remaining-work storage for all task slots, one read index.
// ----------------------------------------------------------------------------
module rrqs_task_table
  import rrqs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  table_wr_t          wr,
  input  logic [TASK_W-1:0]  rd_idx,
  output logic [BURST_W-1:0] rem_rd,
  output logic [BURST_W-1:0] burst_rd
);

  logic [BURST_W-1:0] rem_mem   [TASK_COUNT];
  logic [BURST_W-1:0] burst_mem [TASK_COUNT];

  // A load sets both burst and remaining work; a slice updates remaining work.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_COUNT; i++) begin
        rem_mem[i]   <= '0;
        burst_mem[i] <= '0;
      end
    end else begin
      if (wr.load_en) begin
        rem_mem[wr.load_idx]   <= wr.load_burst;
        burst_mem[wr.load_idx] <= wr.load_burst;
      end else if (wr.upd_en) begin
        rem_mem[wr.upd_idx] <= wr.upd_rem;
      end
    end
  end

  // Both arrays are read at the sequencer's current slot.
  assign rem_rd   = rem_mem[rd_idx];
  assign burst_rd = burst_mem[rd_idx];

endmodule

/* hw/rtl/round_robin_quantum_scheduler.sv */
// Load request: accepted while idle, no result; the block stays ready.
// Run request: accept, then a search of one slot per cycle through the
// shared nonzero test, a slice state (skipped when no slot has work), then a
// result state that waits for a free output. in_ready stays low until then.
// Synchronous active-high reset clears all slots, sets the clock to zero,
// the last served slot to the final one and the quantum to one.
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler
// Round-robin task scheduler with a configurable quantum and saturating clock.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler
  import rrqs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [SLOT_W-1:0]  task_index,
  input  logic [BURST_W-1:0] burst_length,
  // Result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SLOT_W-1:0]  served_task,
  output logic [Q_W-1:0]     slice_length,
  output logic [CLOCK_W-1:0] clock_now,
  output logic               finished,
  output logic [CLOCK_W-1:0] turnaround,
  output logic [CLOCK_W-1:0] waiting,
  output logic               idle,
  // Configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [Q_W-1:0]     quantum
);

  localparam logic [TASK_W-1:0] LAST_SLOT = TASK_W'(TASK_COUNT - 1);

  state_t             state, state_next;
  logic [TASK_W-1:0]  ptr;
  logic [TASK_W-1:0]  cnt;
  logic [TASK_W-1:0]  last_served;
  logic [CLOCK_W-1:0] elapsed_clock;
  logic [Q_W-1:0]     cur_quantum;
  logic [Q_W-1:0]     slice_r;
  logic               done_r;
  logic               res_idle;

  logic               accept;
  logic               out_free;
  logic               emit_go;
  logic               rem_nz;
  logic               in_range;
  logic [31:0]        index_ext;
  logic [31:0]        ptr_ext;
  logic [Q_W-1:0]     q_eff;
  logic [Q_W-1:0]     slice;
  logic [BURST_W-1:0] rem_left;
  logic [CLOCK_W:0]   clock_sum;
  logic [CLOCK_W-1:0] clock_sat;
  logic [CLOCK_W:0]   wait_diff;
  logic [CLOCK_W-1:0] wait_val;
  logic [BURST_W-1:0] rem_rd;
  logic [BURST_W-1:0] burst_rd;
  table_wr_t          tbl_wr;

  function automatic logic [TASK_W-1:0] next_slot(input logic [TASK_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  // Task storage.
  rrqs_task_table u_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (tbl_wr),
    .rd_idx   (ptr),
    .rem_rd   (rem_rd),
    .burst_rd (burst_rd)
  );

  // Handshake and control outputs of the sequencer.
  always_comb begin
    in_ready  = (state == ST_IDLE);
    cfg_ready = 1'b1;
    out_free  = !out_valid || out_ready;
    emit_go   = (state == ST_EMIT) && out_free;
  end

  assign accept = in_valid && in_ready;

  // Shared unit: nonzero test on the slot under the pointer, then slice math.
  always_comb begin
    rem_nz    = (rem_rd != '0);
    q_eff     = (cur_quantum == '0) ? Q_W'(1) : cur_quantum;
    slice     = (rem_rd < BURST_W'(q_eff)) ? rem_rd[Q_W-1:0] : q_eff;
    rem_left  = rem_rd - BURST_W'(slice);
    clock_sum = {1'b0, elapsed_clock} + (CLOCK_W + 1)'(slice);
    clock_sat = clock_sum[CLOCK_W] ? CLOCK_MAX : clock_sum[CLOCK_W-1:0];
    wait_diff = {1'b0, elapsed_clock} - (CLOCK_W + 1)'(burst_rd);
    wait_val  = wait_diff[CLOCK_W] ? '0 : wait_diff[CLOCK_W-1:0];
  end

  // Table write command: loads in idle, remaining work in the slice cycle.
  always_comb begin
    index_ext         = 32'(task_index);
    ptr_ext           = 32'(ptr);
    in_range          = (index_ext < 32'(TASK_COUNT));
    tbl_wr.load_en    = accept && (mode == MODE_LOAD) && in_range;
    tbl_wr.load_idx   = index_ext[TASK_W-1:0];
    tbl_wr.load_burst = burst_length;
    tbl_wr.upd_en     = (state == ST_SLICE);
    tbl_wr.upd_idx    = ptr;
    tbl_wr.upd_rem    = rem_left;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (mode == MODE_RUN)) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (rem_nz) state_next = ST_SLICE;
        else if (cnt == LAST_SLOT) state_next = ST_EMIT;
      end
      ST_SLICE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Quantum register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_quantum <= Q_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      cur_quantum <= quantum;
    end
  end

  // Search pointer, slot counter and scheduler state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr           <= '0;
      cnt           <= '0;
      last_served   <= LAST_SLOT;
      elapsed_clock <= '0;
    end else begin
      if (accept && (mode == MODE_RUN)) begin
        ptr <= next_slot(last_served);
        cnt <= '0;
      end else if ((state == ST_SEARCH) && !rem_nz && (cnt != LAST_SLOT)) begin
        ptr <= next_slot(ptr);
        cnt <= cnt + 1'b1;
      end
      if (state == ST_SLICE) begin
        last_served   <= ptr;
        elapsed_clock <= clock_sat;
      end
    end
  end

  // Working results of the current run request.
  always_ff @(posedge clk) begin
    if (accept) res_idle <= 1'b0;
    else if ((state == ST_SEARCH) && !rem_nz && (cnt == LAST_SLOT)) res_idle <= 1'b1;
    if (state == ST_SLICE) begin
      slice_r <= slice;
      done_r  <= (rem_left == '0);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      clock_now <= elapsed_clock;
      idle      <= res_idle;
      if (res_idle) begin
        served_task  <= '0;
        slice_length <= '0;
        finished     <= 1'b0;
        turnaround   <= '0;
        waiting      <= '0;
      end else begin
        served_task  <= ptr_ext[SLOT_W-1:0];
        slice_length <= slice_r;
        finished     <= done_r;
        turnaround   <= done_r ? elapsed_clock : '0;
        waiting      <= done_r ? wait_val : '0;
      end
    end
  end

endmodule

/* hw/rtl/rrqs_checker.sv */
// ----------------------------------------------------------------------------
// rrqs_checker
// Port-level checks on the scheduler's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "round_robin_quantum_scheduler_defines.svh"

module rrqs_checker
  import rrqs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SLOT_W-1:0]  served_task,
  input logic [Q_W-1:0]     slice_length,
  input logic [CLOCK_W-1:0] clock_now,
  input logic               finished,
  input logic [CLOCK_W-1:0] turnaround,
  input logic [CLOCK_W-1:0] waiting,
  input logic               idle
);

  // No result is shown in the cycle after reset.
  `RRQS_ASSERT_ALWAYS(a_no_result_after_reset, clk, $past(rst) |-> !out_valid)

  // A stalled result holds its payload.
  `RRQS_ASSERT(a_result_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(served_task) && $stable(clock_now) && $stable(waiting))

  // An idle result serves nothing.
  `RRQS_ASSERT(a_idle_empty, clk, rst, out_valid && idle |-> !finished && slice_length == '0 && served_task == '0)

  // An unfinished slice reports no turnaround or waiting time.
  `RRQS_ASSERT(a_unfinished_zero, clk, rst, out_valid && !finished |-> turnaround == '0 && waiting == '0)

  // A finished task completes at the current clock and waits no longer than that.
  `RRQS_ASSERT(a_finish_times, clk, rst, out_valid && finished |-> turnaround == clock_now && waiting <= turnaround && slice_length != '0)

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .served_task  (served_task),
  .slice_length (slice_length),
  .clock_now    (clock_now),
  .finished     (finished),
  .turnaround   (turnaround),
  .waiting      (waiting),
  .idle         (idle)
);

/* tb/sv/round_robin_quantum_scheduler_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_tb
// Self-checking bench for the round-robin quantum scheduler. A table of
// directed requests comes first, then random load and run traffic under
// several quantum settings. Every run request is predicted by a behavioral
// copy of the scheduler, and each result is compared in order with its
// prediction.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler_tb;
  import rrqs_pkg::*;

  // One scheduling result as it appears on the result channel.
  typedef struct packed {
    logic [SLOT_W-1:0]  served_task;
    logic [Q_W-1:0]     slice_len;
    logic [CLOCK_W-1:0] clock_now;
    logic               finished;
    logic [CLOCK_W-1:0] turnaround;
    logic [CLOCK_W-1:0] wait_len;
    logic               idle_flag;
  } slice_result_t;

  // A directed row is either a request or a quantum write.
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               mode;
    logic [SLOT_W-1:0]  slot;
    logic [BURST_W-1:0] value;
    logic               typed;
    slice_result_t      want_res;
  } dir_row_t;

  localparam int N_DIRECTED = 26;
  localparam int SETTLE_CYCLES = TASK_COUNT + 4;

  // Clock, reset and the block's inputs, all known from time zero.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               mode = MODE_LOAD;
  logic [SLOT_W-1:0]  task_index = '0;
  logic [BURST_W-1:0] burst_length = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [SLOT_W-1:0]  served_task;
  logic [Q_W-1:0]     slice_length;
  logic [CLOCK_W-1:0] clock_now;
  logic               finished;
  logic [CLOCK_W-1:0] turnaround;
  logic [CLOCK_W-1:0] waiting;
  logic               idle;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [Q_W-1:0]     quantum = 8'd1;

  // A typed expectation that travels with the request it belongs to.
  logic               row_typed = 1'b0;
  slice_result_t      row_want = '0;

  // Scheduler state as the bench predicts it.
  logic [BURST_W-1:0] pred_remaining [TASK_COUNT] = '{default: '0};
  logic [BURST_W-1:0] pred_burst [TASK_COUNT] = '{default: '0};
  logic [TASK_W-1:0]  pred_last = TASK_W'(TASK_COUNT - 1);
  logic [CLOCK_W-1:0] pred_clock = '0;
  logic [Q_W-1:0]     pred_quantum = 8'd1;

  slice_result_t      pending_slices [$];
  int                 bad_slices = 0;
  bit                 quiet = 1'b0;

  // Directed requests. Quantum starts at one after reset.
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b1,
      '{3'd0, 8'd0, 24'd0, 1'b0, 24'd0, 24'd0, 1'b1}},
    '{ROW_REQ, MODE_LOAD, 3'd7, 16'd1, 1'b0, '0},
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b1,
      '{3'd7, 8'd1, 24'd1, 1'b1, 24'd1, 24'd0, 1'b0}},
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b1,
      '{3'd0, 8'd0, 24'd1, 1'b0, 24'd0, 24'd0, 1'b1}},
    '{ROW_REQ, MODE_LOAD, 3'd0, 16'hFFFF, 1'b0, '0},
    '{ROW_REQ, MODE_LOAD, 3'd3, 16'd2, 1'b0, '0},
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b0, '0},
    '{ROW_REQ, MODE_RUN, 3'd7, 16'hFFFF, 1'b0, '0},
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b0, '0},
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b0, '0},
    '{ROW_CFG, MODE_LOAD, 3'd0, 16'd0, 1'b0, '0},
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b0, '0},
    '{ROW_CFG, MODE_LOAD, 3'd0, 16'd255, 1'b0, '0},
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b0, '0},
    '{ROW_REQ, MODE_LOAD, 3'd0, 16'd0, 1'b0, '0},
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b1,
      '{3'd0, 8'd0, 24'd261, 1'b0, 24'd0, 24'd0, 1'b1}},
    '{ROW_REQ, MODE_LOAD, 3'd4, 16'd300, 1'b0, '0},
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b0, '0},
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b0, '0},
    '{ROW_CFG, MODE_LOAD, 3'd0, 16'd1, 1'b0, '0},
    '{ROW_REQ, MODE_LOAD, 3'd1, 16'd1, 1'b0, '0},
    '{ROW_REQ, MODE_LOAD, 3'd6, 16'd2, 1'b0, '0},
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b0, '0},
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b0, '0},
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b0, '0},
    '{ROW_REQ, MODE_RUN, 3'd0, 16'd0, 1'b0, '0}
  };

  round_robin_quantum_scheduler dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .task_index   (task_index),
    .burst_length (burst_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .served_task  (served_task),
    .slice_length (slice_length),
    .clock_now    (clock_now),
    .finished     (finished),
    .turnaround   (turnaround),
    .waiting      (waiting),
    .idle         (idle),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .quantum      (quantum)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Serve one run request: search from the slot after the last one served,
  // run the first task with work left for at most one quantum.
  function automatic slice_result_t run_slice();
    slice_result_t r;
    int unsigned   k, slot, q, cut, total;
    bit            found;
    r = '0;
    found = 1'b0;
    slot = 0;
    for (k = 1; k <= TASK_COUNT && !found; k++) begin
      slot = (pred_last + k) % TASK_COUNT;
      found = (pred_remaining[slot] != 0);
    end
    if (!found) begin
      r.clock_now = pred_clock;
      r.idle_flag = 1'b1;
    end else begin
      pred_last = slot[TASK_W-1:0];
      // A quantum of zero behaves as one.
      q = (pred_quantum == 0) ? 1 : pred_quantum;
      cut = (pred_remaining[slot] < q) ? pred_remaining[slot] : q;
      // The clock saturates instead of wrapping.
      total = pred_clock + cut;
      pred_clock = (total > CLOCK_MAX) ? CLOCK_MAX : total[CLOCK_W-1:0];
      pred_remaining[slot] = pred_remaining[slot] - cut[BURST_W-1:0];
      r.served_task = slot[SLOT_W-1:0];
      r.slice_len = cut[Q_W-1:0];
      r.clock_now = pred_clock;
      if (pred_remaining[slot] == 0) begin
        r.finished = 1'b1;
        r.turnaround = pred_clock;
        r.wait_len = (pred_clock >= pred_burst[slot]) ?
                     pred_clock - pred_burst[slot] : '0;
      end
    end
    return r;
  endfunction

  function automatic string fmt_slice(slice_result_t r);
    return $sformatf("task %0d slice %0d clock %0d fin %0d tat %0d wait %0d idle %0d",
                     r.served_task, r.slice_len, r.clock_now, r.finished,
                     r.turnaround, r.wait_len, r.idle_flag);
  endfunction

  // Result stall: ready drops with a chance of about 16 in a hundred, never while quiet.
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 16);
  end

  // Check results in order, then track accepted writes and requests.
  always @(posedge clk) begin
    slice_result_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{served_task, slice_length, clock_now, finished,
                turnaround, waiting, idle};
        if (pending_slices.size() == 0) begin
          bad_slices++;
          if (bad_slices <= 10)
            $display("Unexpected result: %s", fmt_slice(got));
        end else begin
          want = pending_slices.pop_front();
          if (got !== want) begin
            bad_slices++;
            if (bad_slices <= 10) begin
              $display("Result mismatch: expected %s", fmt_slice(want));
              $display("                 actual   %s", fmt_slice(got));
            end
          end
        end
      end
      if (cfg_valid && cfg_ready)
        pred_quantum = quantum;
      if (in_valid && in_ready) begin
        if (mode == MODE_LOAD) begin
          if (task_index < TASK_COUNT) begin
            pred_burst[task_index] = burst_length;
            pred_remaining[task_index] = burst_length;
          end
        end else begin
          want = run_slice();
          if (row_typed)
            want = row_want;
          pending_slices.push_back(want);
        end
      end
    end
  end

  // Present one request, with an occasional gap before it, and hold it
  // until it is accepted.
  task automatic send_request(input logic m, input logic [SLOT_W-1:0] slot,
                              input logic [BURST_W-1:0] b, input logic typed,
                              input slice_result_t want_res);
    if (!quiet && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    task_index <= slot;
    burst_length <= b;
    row_typed <= typed;
    row_want <= want_res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drain all outstanding results, let the block settle, then write the
  // quantum register.
  task automatic write_quantum(input logic [Q_W-1:0] q);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_slices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    quantum <= q;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Run limit, far above the slowest correct run.
  initial begin
    #10_000_000;
    $display("round_robin_quantum_scheduler_tb: FAIL");
    $finish;
  end

  // Main stimulus.
  initial begin
    logic [Q_W-1:0]     phase_q [4];
    logic [BURST_W-1:0] b;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_quantum(directed_rows[i].value[Q_W-1:0]);
      else
        send_request(directed_rows[i].mode, directed_rows[i].slot,
                     directed_rows[i].value, directed_rows[i].typed,
                     directed_rows[i].want_res);
    end

    // Random traffic under several quantum settings; the second phase
    // starts with a stretch free of stalls on both sides.
    phase_q = '{8'd2, 8'd255, 8'd0, 8'($urandom_range(1, 255))};
    for (int ph = 0; ph < 4; ph++) begin
      write_quantum(phase_q[ph]);
      for (int n = 0; n < 100; n++) begin
        quiet = (ph == 1 && n < 60);
        if ($urandom_range(0, 99) < 45) begin
          // Mostly short bursts so tasks finish, some absent, some wide.
          case ($urandom_range(0, 9))
            0:       b = '0;
            1, 2:    b = BURST_W'($urandom);
            default: b = BURST_W'($urandom_range(1, 40));
          endcase
          send_request(MODE_LOAD, SLOT_W'($urandom_range(0, TASK_COUNT - 1)),
                       b, 1'b0, '0);
        end else begin
          send_request(MODE_RUN, SLOT_W'($urandom), BURST_W'($urandom), 1'b0, '0);
        end
      end
    end
    quiet = 1'b0;

    // Wait for the last results and let the block settle.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_slices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_slices == 0)
      $display("round_robin_quantum_scheduler_tb: PASS");
    else
      $display("round_robin_quantum_scheduler_tb: FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/rrqs_pkg.sv
hw/rtl/rrqs_task_table.sv
hw/rtl/round_robin_quantum_scheduler.sv
hw/rtl/rrqs_checker.sv
tb/sv/round_robin_quantum_scheduler_tb.sv
